### sv/psf_pkg.sv
package psf_pkg;

   localparam int PSF_FRAC_BITS = 16;
   localparam int POS_W = 32;
   localparam int DIFF_W = 33;
   localparam int SUM_W = 66;
   localparam int SQ_W = 68;
   localparam int ROOT_W = 34;
   localparam int CFG_W = 31;
   localparam int QUEUE_DEPTH = 8;
   localparam int FRONT_STAGES = 3;

   localparam logic CSR_STIFFNESS = 1'b0;
   localparam logic CSR_REST_LEN = 1'b1;

   // One classified item on its way from the front end to the back end.
   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic [SUM_W-1:0] sum;
      logic zero;
   } psf_entry_type;

endpackage

### sv/psf_front.sv
module psf_front (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic signed [psf_pkg::POS_W-1:0] particle_x,
   input  logic signed [psf_pkg::POS_W-1:0] particle_y,
   input  logic signed [psf_pkg::POS_W-1:0] particle_z,
   input  logic signed [psf_pkg::POS_W-1:0] anchor_x,
   input  logic signed [psf_pkg::POS_W-1:0] anchor_y,
   input  logic signed [psf_pkg::POS_W-1:0] anchor_z,
   output logic push,
   output psf_pkg::psf_entry_type push_data
);
   import psf_pkg::*;

   logic [2:0][DIFF_W-1:0] d_in, d1_ff, d2_ff;
   logic zero1_ff, zero2_ff;
   logic v1_ff, v2_ff, push_ff;
   logic [2:0][SUM_W-1:0] sq_in, sq_ff;
   logic [2:0][DIFF_W-1:0] ad;
   psf_entry_type entry_ff;

   always_comb begin
      d_in[0] = DIFF_W'($signed(particle_x)) - DIFF_W'($signed(anchor_x));
      d_in[1] = DIFF_W'($signed(particle_y)) - DIFF_W'($signed(anchor_y));
      d_in[2] = DIFF_W'($signed(particle_z)) - DIFF_W'($signed(anchor_z));
      for (int i = 0; i < 3; i++) begin
         ad[i] = d1_ff[i][DIFF_W-1] ? (~d1_ff[i] + 1'b1) : d1_ff[i];
         sq_in[i] = SUM_W'(ad[i]) * SUM_W'(ad[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         push_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         push_ff <= v2_ff;
      end
      d1_ff <= d_in;
      zero1_ff <= (d_in == '0);
      d2_ff <= d1_ff;
      zero2_ff <= zero1_ff;
      sq_ff <= sq_in;
      entry_ff.d <= d2_ff;
      entry_ff.zero <= zero2_ff;
      entry_ff.sum <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   assign push = push_ff;
   assign push_data = entry_ff;

endmodule

### sv/psf_queue.sv
module psf_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  psf_pkg::psf_entry_type push_data,
   output logic almost_full,
   output logic overflow,
   output logic pop_valid,
   output psf_pkg::psf_entry_type pop_data
);
   import psf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   psf_entry_type mem [QUEUE_DEPTH];
   psf_entry_type out_ff;
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic out_valid_ff;
   logic pop;

   assign pop = (cnt_ff != '0);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_in;
         out_valid_ff <= pop;
      end
      if (push) mem[wr_ff] <= push_data;
      if (pop) out_ff <= mem[rd_ff];
   end

   // Leave room for the items still inside the front end.
   assign almost_full = (cnt_ff > CNT_W'(QUEUE_DEPTH - FRONT_STAGES - 1));
   assign overflow = push && (cnt_ff == CNT_W'(QUEUE_DEPTH)) && !pop;
   assign pop_valid = out_valid_ff;
   assign pop_data = out_ff;

endmodule

### sv/psf_back.sv
module psf_back #(
   parameter int FRAC_BITS = psf_pkg::PSF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  psf_pkg::psf_entry_type in_data,
   input  logic [psf_pkg::CFG_W-1:0] stiffness,
   input  logic [psf_pkg::CFG_W-1:0] rest_len,
   output logic out_valid,
   output logic signed [psf_pkg::POS_W-1:0] force_x,
   output logic signed [psf_pkg::POS_W-1:0] force_y,
   output logic signed [psf_pkg::POS_W-1:0] force_z,
   output logic saturated
);
   import psf_pkg::*;

   localparam int KP_W = CFG_W + ROOT_W;
   localparam int MAG_W = KP_W - FRAC_BITS;
   localparam int Q_W = FRAC_BITS + 1;
   localparam int R_W = ROOT_W + 1;
   localparam int PLO_W = 32 + Q_W;
   localparam int PHI_W = MAG_W - 32 + Q_W;
   localparam int PROD_W = MAG_W + Q_W;
   localparam int V_W = 64 - FRAC_BITS;

   typedef struct packed {
      logic [2:0][DIFF_W-1:0] d;
      logic zero;
      logic [SQ_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [2:0][R_W-1:0] r;
      logic [2:0][Q_W-1:0] q;
      logic [ROOT_W-1:0] len;
      logic [MAG_W-1:0] mag;
      logic [2:0] neg;
      logic zero;
   } dv_type;

   typedef struct packed {
      logic [2:0][PLO_W-1:0] plo;
      logic [2:0][PHI_W-1:0] phi;
      logic [2:0] neg;
      logic zero;
   } mu_type;

   // Square root: one result bit per stage.
   sq_type sq_ff [ROOT_W];
   logic sq_vld_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
      localparam int B = ROOT_W - 1 - s;
      sq_type src, nxt;
      logic src_vld;
      logic [SQ_W-1:0] trial;
      if (s == 0) begin : g_first
         assign src = '{d: in_data.d, zero: in_data.zero,
                        rem: SQ_W'(in_data.sum), root: '0};
         assign src_vld = in_valid;
      end else begin : g_next
         assign src = sq_ff[s-1];
         assign src_vld = sq_vld_ff[s-1];
      end
      always_comb begin
         trial = (SQ_W'(src.root) << (B + 1)) | (SQ_W'(1) << (2 * B));
         nxt = src;
         if (src.rem >= trial) begin
            nxt.rem = src.rem - trial;
            nxt.root = src.root | (ROOT_W'(1) << B);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) sq_vld_ff[s] <= 1'b0;
         else sq_vld_ff[s] <= src_vld;
         sq_ff[s] <= nxt;
      end
   end

   // Extension and magnitude k * |L - rest| in one stage.
   dv_type mg_ff, mg_in;
   logic mg_vld_ff;
   logic [ROOT_W-1:0] len, ext;
   logic [KP_W-1:0] kp;
   logic [DIFF_W-1:0] dabs;

   always_comb begin
      len = sq_ff[ROOT_W-1].root;
      ext = (len >= ROOT_W'(rest_len)) ? len - ROOT_W'(rest_len) : ROOT_W'(rest_len) - len;
      kp = KP_W'(stiffness) * KP_W'(ext);
      mg_in.len = len;
      mg_in.mag = kp[KP_W-1:FRAC_BITS];
      mg_in.zero = sq_ff[ROOT_W-1].zero;
      mg_in.q = '0;
      dabs = '0;
      for (int i = 0; i < 3; i++) begin
         mg_in.neg[i] = sq_ff[ROOT_W-1].d[i][DIFF_W-1];
         dabs = mg_in.neg[i] ? (~sq_ff[ROOT_W-1].d[i] + 1'b1) : sq_ff[ROOT_W-1].d[i];
         mg_in.r[i] = R_W'(dabs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mg_vld_ff <= 1'b0;
      else mg_vld_ff <= sq_vld_ff[ROOT_W-1];
      mg_ff <= mg_in;
   end

   // Unit direction |d| * 2^F / L: one quotient bit per stage, three lanes.
   dv_type dv_ff [Q_W];
   logic dv_vld_ff [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      dv_type src, nxt;
      logic src_vld;
      logic [R_W-1:0] rr;
      logic ge;
      if (j == 0) begin : g_first
         assign src = mg_ff;
         assign src_vld = mg_vld_ff;
      end else begin : g_next
         assign src = dv_ff[j-1];
         assign src_vld = dv_vld_ff[j-1];
      end
      always_comb begin
         nxt = src;
         rr = '0;
         ge = 1'b0;
         for (int i = 0; i < 3; i++) begin
            ge = (src.r[i] >= R_W'(src.len));
            rr = ge ? src.r[i] - R_W'(src.len) : src.r[i];
            nxt.q[i] = {src.q[i][Q_W-2:0], ge};
            nxt.r[i] = {rr[R_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[j] <= 1'b0;
         else dv_vld_ff[j] <= src_vld;
         dv_ff[j] <= nxt;
      end
   end

   // Magnitude times direction, split into two partial products.
   mu_type mu_ff, mu_in;
   logic mu_vld_ff;

   always_comb begin
      mu_in.neg = dv_ff[Q_W-1].neg;
      mu_in.zero = dv_ff[Q_W-1].zero;
      for (int i = 0; i < 3; i++) begin
         mu_in.plo[i] = PLO_W'(dv_ff[Q_W-1].mag[31:0]) * PLO_W'(dv_ff[Q_W-1].q[i]);
         mu_in.phi[i] = PHI_W'(dv_ff[Q_W-1].mag[MAG_W-1:32]) * PHI_W'(dv_ff[Q_W-1].q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mu_vld_ff <= 1'b0;
      else mu_vld_ff <= dv_vld_ff[Q_W-1];
      mu_ff <= mu_in;
   end

   // Recombine, scale and saturate.
   logic [2:0][POS_W-1:0] f_in, f_ff;
   logic sat_in, sat_ff, out_vld_ff;
   logic [PROD_W-1:0] prod;
   logic over;
   logic [V_W-1:0] v;

   always_comb begin
      f_in = '0;
      sat_in = 1'b0;
      prod = '0;
      over = 1'b0;
      v = '0;
      for (int i = 0; i < 3; i++) begin
         prod = PROD_W'(mu_ff.plo[i]) + (PROD_W'(mu_ff.phi[i]) << 32);
         over = |prod[PROD_W-1:64];
         v = prod[63:FRAC_BITS];
         if (mu_ff.neg[i]) begin
            if (over || v > V_W'(32'h7FFF_FFFF)) begin
               f_in[i] = 32'h7FFF_FFFF;
               sat_in = 1'b1;
            end else begin
               f_in[i] = v[POS_W-1:0];
            end
         end else begin
            if (over || v > V_W'(32'h8000_0000)) begin
               f_in[i] = 32'h8000_0000;
               sat_in = 1'b1;
            end else begin
               f_in[i] = ~v[POS_W-1:0] + 1'b1;
            end
         end
      end
      if (mu_ff.zero) begin
         f_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= mu_vld_ff;
      f_ff <= f_in;
      sat_ff <= sat_in;
   end

   assign out_valid = out_vld_ff;
   assign force_x = f_ff[0];
   assign force_y = f_ff[1];
   assign force_z = f_ff[2];
   assign saturated = sat_ff;

endmodule

### sv/particle_spring_force_unit.sv
// Spring force unit: one force vector per transaction, of size k * |L - rest| and always pointing toward the anchor.
// Throughput: one transaction per cycle while busy is low; every stage of the back end is a fixed pipeline step.
// The result receiver cannot stall, so busy only rises if the decoupling queue backs up.
// Reset is synchronous and active high; it clears all valid flags and queue pointers and
// restores stiffness to 1.0 and rest length to 0.
module particle_spring_force_unit #(
   parameter int FRAC_BITS = psf_pkg::PSF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [psf_pkg::POS_W-1:0] req_particle_x,
   input  logic signed [psf_pkg::POS_W-1:0] req_particle_y,
   input  logic signed [psf_pkg::POS_W-1:0] req_particle_z,
   input  logic signed [psf_pkg::POS_W-1:0] req_anchor_x,
   input  logic signed [psf_pkg::POS_W-1:0] req_anchor_y,
   input  logic signed [psf_pkg::POS_W-1:0] req_anchor_z,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [psf_pkg::CFG_W-1:0] csr_wdata,
   output logic rsp_valid,
   output logic signed [psf_pkg::POS_W-1:0] rsp_force_x,
   output logic signed [psf_pkg::POS_W-1:0] rsp_force_y,
   output logic signed [psf_pkg::POS_W-1:0] rsp_force_z,
   output logic rsp_saturated
);
   import psf_pkg::*;

   // The front end forms the difference vector, its squared length and a
   // zero-length flag. The queue decouples it from the back end, which takes
   // the square root one bit per stage, divides the three components one
   // quotient bit per stage and finally scales and saturates the force.

   logic [CFG_W-1:0] stiff_ff, rest_ff;
   logic accept;
   logic push, almost_full, overflow, pop_valid;
   psf_entry_type push_data, pop_data;

   assign accept = start && !busy;
   assign busy = almost_full;

   // Configuration registers; a write lands at the clock edge it is presented.
   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= CFG_W'(65536);
         rest_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STIFFNESS: stiff_ff <= csr_wdata;
            CSR_REST_LEN: rest_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   psf_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .particle_x(req_particle_x),
      .particle_y(req_particle_y),
      .particle_z(req_particle_z),
      .anchor_x(req_anchor_x),
      .anchor_y(req_anchor_y),
      .anchor_z(req_anchor_z),
      .push(push),
      .push_data(push_data)
   );

   psf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .almost_full(almost_full),
      .overflow(overflow),
      .pop_valid(pop_valid),
      .pop_data(pop_data)
   );

   psf_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_valid(pop_valid),
      .in_data(pop_data),
      .stiffness(stiff_ff),
      .rest_len(rest_ff),
      .out_valid(rsp_valid),
      .force_x(rsp_force_x),
      .force_y(rsp_force_y),
      .force_z(rsp_force_z),
      .saturated(rsp_saturated)
   );

   // The queue must never drop an item coming out of the front end.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !overflow)
      else $error("spring force queue overflow");

   // A saturated result carries at least one clipped component.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_force_x == 32'sh7FFF_FFFF) || (rsp_force_x == 32'sh8000_0000) ||
         (rsp_force_y == 32'sh7FFF_FFFF) || (rsp_force_y == 32'sh8000_0000) ||
         (rsp_force_z == 32'sh7FFF_FFFF) || (rsp_force_z == 32'sh8000_0000))
      else $error("saturated flag without a clipped component");

   // A rest length write is visible in the next cycle.
   a_rest_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_REST_LEN) |=> rest_ff == $past(csr_wdata))
      else $error("rest length write lost");

endmodule

### tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import psf_pkg::*;

   // One force vector as the block reports it.
   typedef struct {
      logic [POS_W-1:0] fx;
      logic [POS_W-1:0] fy;
      logic [POS_W-1:0] fz;
      logic sat;
   } force_vec_type;

   // Scoreboard: it keeps its own copy of the two spring registers, works out
   // the force for every accepted transaction and checks results in order.
   class spring_scoreboard;
      logic [CFG_W-1:0] stiffness;
      logic [CFG_W-1:0] rest_len_reg;
      force_vec_type pending_forces[$];
      int errors;
      int checked;
      int sat_seen;
      int zero_seen;

      function new();
         stiffness = 31'd65536;
         rest_len_reg = '0;
         errors = 0;
         checked = 0;
         sat_seen = 0;
         zero_seen = 0;
      endfunction

      function void write_reg(logic idx, logic [CFG_W-1:0] value);
         if (idx == CSR_STIFFNESS) begin
            stiffness = value;
         end else begin
            rest_len_reg = value;
         end
      endfunction

      // Force component for one axis: direction from d, magnitude mag, length len.
      function automatic logic [POS_W-1:0] axis_force(logic signed [DIFF_W-1:0] d,
            logic [ROOT_W-1:0] len, logic [63:0] mag, ref logic sat);
         logic [DIFF_W-1:0] ad;
         logic [63:0] unit;
         logic [127:0] prod;
         logic [63:0] v;
         if (d == 0) begin
            return '0;
         end
         ad = (d < 0) ? -d : d;
         unit = ({31'd0, ad} << PSF_FRAC_BITS) / {30'd0, len};
         if (unit == 0) begin
            return '0;
         end
         prod = {64'd0, mag} * {64'd0, unit};
         if (prod[127:64] != 0) begin
            sat = 1'b1;
            return (d > 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         v = prod[63:0] >> PSF_FRAC_BITS;
         if (d > 0) begin
            if (v > 64'h8000_0000) begin
               sat = 1'b1;
               return 32'h8000_0000;
            end
            return -v[31:0];
         end
         if (v > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return v[31:0];
      endfunction

      function automatic force_vec_type spring_force(logic signed [POS_W-1:0] p[3],
            logic signed [POS_W-1:0] a[3]);
         logic signed [DIFF_W-1:0] d[3];
         logic [DIFF_W-1:0] ad;
         logic [SQ_W-1:0] sum_sq;
         logic [ROOT_W-1:0] root;
         logic [ROOT_W-1:0] cand;
         logic [SQ_W-1:0] cand_sq;
         logic [ROOT_W-1:0] ext;
         logic [127:0] kprod;
         logic [63:0] mag;
         logic sat;
         force_vec_type r;
         sum_sq = '0;
         for (int i = 0; i < 3; i++) begin
            d[i] = DIFF_W'(p[i]) - DIFF_W'(a[i]);
            ad = (d[i] < 0) ? -d[i] : d[i];
            sum_sq += {35'd0, ad} * {35'd0, ad};
         end
         // Integer square root, one bit per step from the top.
         root = '0;
         for (int b = ROOT_W - 1; b >= 0; b--) begin
            cand = root | (ROOT_W'(1) << b);
            cand_sq = {34'd0, cand} * {34'd0, cand};
            if (cand_sq <= sum_sq) begin
               root = cand;
            end
         end
         r = '{default: '0};
         if (root == 0) begin
            return r;
         end
         ext = (root >= {3'd0, rest_len_reg}) ? root - rest_len_reg : rest_len_reg - root;
         kprod = {97'd0, stiffness} * {94'd0, ext};
         mag = kprod[63:0] >> PSF_FRAC_BITS;
         sat = 1'b0;
         r.fx = axis_force(d[0], root, mag, sat);
         r.fy = axis_force(d[1], root, mag, sat);
         r.fz = axis_force(d[2], root, mag, sat);
         r.sat = sat;
         return r;
      endfunction

      function void note_request(logic signed [POS_W-1:0] p[3],
            logic signed [POS_W-1:0] a[3]);
         pending_forces.insert(pending_forces.size(), spring_force(p, a));
      endfunction

      task report(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
         $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_response(force_vec_type got);
         force_vec_type want;
         if (pending_forces.size() == 0) begin
            report("unexpected result transaction", got.fx, '0);
            return;
         end
         want = pending_forces.pop_front();
         checked++;
         if (got.sat) sat_seen++;
         if (got.fx == 0 && got.fy == 0 && got.fz == 0) zero_seen++;
         if (got.fx !== want.fx) report("force_x", got.fx, want.fx);
         if (got.fy !== want.fy) report("force_y", got.fy, want.fy);
         if (got.fz !== want.fz) report("force_z", got.fz, want.fz);
         if (got.sat !== want.sat) report("saturated", 32'(got.sat), 32'(want.sat));
      endtask
   endclass

   localparam int LATENCY = PSF_FRAC_BITS + 42;
   localparam int RANDOM_ITEMS = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [POS_W-1:0] req_particle_x = '0;
   logic signed [POS_W-1:0] req_particle_y = '0;
   logic signed [POS_W-1:0] req_particle_z = '0;
   logic signed [POS_W-1:0] req_anchor_x = '0;
   logic signed [POS_W-1:0] req_anchor_y = '0;
   logic signed [POS_W-1:0] req_anchor_z = '0;
   logic csr_we = 1'b0;
   logic csr_index = CSR_STIFFNESS;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [POS_W-1:0] rsp_force_x;
   logic signed [POS_W-1:0] rsp_force_y;
   logic signed [POS_W-1:0] rsp_force_z;
   logic rsp_saturated;

   spring_scoreboard sb = new();
   int sender_idle_pct = 0;
   int items_sent = 0;

   particle_spring_force_unit u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_particle_x(req_particle_x),
      .req_particle_y(req_particle_y),
      .req_particle_z(req_particle_z),
      .req_anchor_x(req_anchor_x),
      .req_anchor_y(req_anchor_y),
      .req_anchor_z(req_anchor_z),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_force_x(rsp_force_x),
      .rsp_force_y(rsp_force_y),
      .rsp_force_z(rsp_force_z),
      .rsp_saturated(rsp_saturated)
   );

   always #5 clock = ~clock;

   // Result monitor. The strobe and the force are sampled at the edge that ends
   // the result cycle, before any update made at that edge lands.
   always @(posedge clock) begin
      force_vec_type got;
      if (!reset && rsp_valid) begin
         got.fx = rsp_force_x;
         got.fy = rsp_force_y;
         got.fz = rsp_force_z;
         got.sat = rsp_saturated;
         sb.check_response(got);
      end
   end

   // Drives one transaction. Inputs change on the falling edge; the transaction
   // counts as accepted at the first rising edge that sees start high and busy low.
   // The task returns on the falling edge after acceptance with start still high,
   // so back-to-back transactions keep start up without a glitch.
   task automatic send_item(logic signed [POS_W-1:0] p[3], logic signed [POS_W-1:0] a[3]);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_particle_x = p[0];
      req_particle_y = p[1];
      req_particle_z = p[2];
      req_anchor_x = a[0];
      req_anchor_y = a[1];
      req_anchor_z = a[2];
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_request(p, a);
      items_sent++;
      @(negedge clock);
   endtask

   // Lowers start and waits for every outstanding force, then lets the pipeline
   // settle before anything else changes.
   task automatic drain();
      start = 1'b0;
      while (sb.pending_forces.size() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Register write; only issued while the block is drained.
   task automatic write_csr(logic idx, logic [CFG_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_vectors(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
         logic signed [POS_W-1:0] pz, logic signed [POS_W-1:0] ax,
         logic signed [POS_W-1:0] ay, logic signed [POS_W-1:0] az);
      logic signed [POS_W-1:0] p[3];
      logic signed [POS_W-1:0] a[3];
      p = '{px, py, pz};
      a = '{ax, ay, az};
      send_item(p, a);
   endtask

   // Random geometry: mostly a random anchor with a nearby particle so the
   // spring length spans many scales; some fully random pairs, some degenerate.
   task automatic send_random();
      logic signed [POS_W-1:0] p[3];
      logic signed [POS_W-1:0] a[3];
      int mode;
      int span;
      mode = $urandom_range(99);
      span = $urandom_range(30, 2);
      for (int i = 0; i < 3; i++) begin
         a[i] = $urandom;
         if (mode < 35) begin
            p[i] = $urandom;
         end else if (mode < 90) begin
            p[i] = a[i] + ($signed($urandom) >>> (32 - span));
         end else if (mode < 95) begin
            p[i] = ($urandom_range(1) == 1) ? a[i] : a[i] + $signed($urandom_range(255)) - 128;
         end else begin
            p[i] = a[i];
         end
      end
      send_item(p, a);
   endtask

   initial begin
      logic [CFG_W-1:0] stiff_set[5];
      logic [CFG_W-1:0] rest_set[5];
      int per_phase;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed transactions under the reset values (k = 1.0, rest length 0).
      send_vectors(0, 0, 0, 0, 0, 0);
      send_vectors(32'sh0001_0000, 0, 0, 0, 0, 0);
      send_vectors(0, -32'sh0003_0000, 0, 0, 0, 0);
      send_vectors(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_vectors(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_vectors(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
      send_vectors(32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678,
         32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678);
      send_vectors(1, 0, 0, 0, 0, 0);
      send_vectors(-1, 1, -1, 0, 0, 0);
      send_vectors(32'sh0002_0000, 32'sh0003_0000, -32'sh0006_0000, 0, 0, 0);
      drain();

      // A compressed spring (rest length longer than the spring) and a very
      // stiff one that clips the force in both directions.
      write_csr(CSR_REST_LEN, 31'h000A_0000);
      write_csr(CSR_STIFFNESS, 31'h0004_0000);
      send_vectors(32'sh0001_0000, 0, 0, 0, 0, 0);
      send_vectors(0, 0, -32'sh0002_0000, 0, 0, 0);
      send_vectors(32'sh000A_0000, 0, 0, 0, 0, 0);
      drain();
      write_csr(CSR_STIFFNESS, 31'h7FFF_FFFF);
      write_csr(CSR_REST_LEN, '0);
      send_vectors(32'sh4000_0000, 32'sh4000_0000, 0, -32'sh4000_0000, 0, 0);
      send_vectors(-32'sh4000_0000, 0, 32'sh7FFF_FFFF, 32'sh4000_0000, 0, 32'sh8000_0000);
      send_vectors(32'sh0000_0100, 0, 0, 0, 0, 0);
      drain();

      // Random phases, each under its own register setting. The sender's idle
      // rate follows the position in the run: light, then heavy, then none.
      stiff_set = '{31'd65536, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd0};
      rest_set = '{31'd0, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0};
      stiff_set[4] = CFG_W'($urandom);
      rest_set[4] = CFG_W'($urandom_range(31'h00FF_FFFF));
      per_phase = RANDOM_ITEMS / 5;
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_STIFFNESS, stiff_set[ph]);
         write_csr(CSR_REST_LEN, rest_set[ph]);
         for (int n = 0; n < per_phase; n++) begin
            int pos;
            pos = ph * per_phase + n;
            sender_idle_pct = (pos < RANDOM_ITEMS / 3) ? 14 :
               (pos < 2 * RANDOM_ITEMS / 3) ? 87 : 0;
            // Once mid-phase the sender holds off until the pipeline is empty.
            if (ph == 2 && n == per_phase / 2) begin
               drain();
            end
            send_random();
         end
         drain();
      end

      $display("Sent %0d spring transactions over several register settings; checked %0d forces.",
         items_sent, sb.checked);
      $display("Forces that clipped: %0d, all-zero forces: %0d.", sb.sat_seen, sb.zero_seen);
      if (sb.errors == 0 && sb.pending_forces.size() == 0) begin
         $display("particle_spring_force_unit verification clean");
      end else begin
         $display("particle_spring_force_unit verification failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #2ms;
      $display("Timed out waiting for the block.");
      $display("particle_spring_force_unit verification failed");
      $finish;
   end

endmodule
